@@ rtl/core/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// No dependencies; imported by the controller, datapath and top level.
package deq_pkg;

  // Field widths of the input and result beats
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Default number of ring slots
  localparam int DEPTH_DEF = 16;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // input beat accepted: run the operation
    logic retire;   // result beat taken by the receiver
  } deq_cmd_t;

endpackage

@@ rtl/core/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit words in a ring of DEPTH slots.
// The result beat is valid in the cycle after the input beat is taken.
// The controller holds one item at a time, so it takes no new input beat until
// the last result beat is taken; pops go through the store's registered read.
// Reset (synchronous, rst_n low) empties the queue; slot contents are kept.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [deq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [deq_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [deq_pkg::STAT_W-1:0]        out_status,
  output logic signed [deq_pkg::WORD_W-1:0] out_popped,
  output logic [deq_pkg::OCC_W-1:0]         out_occupancy
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  // Handshake sequencing
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store and pointers
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_occupancy (out_occupancy)
  );

endmodule

@@ rtl/core/deq_ctrl.sv @@
// Handshake controller for the double-ended queue.
// Depends on deq_pkg; drives the command struct into deq_dpath.
module deq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  // Take a beat only while idle; hold the result until it is taken
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_SEND);
  assign cmd.load    = (state_r == ST_IDLE) && in_valid;
  assign cmd.retire  = (state_r == ST_SEND) && !out_stall;

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.load) state_nxt = ST_SEND;
      ST_SEND: if (cmd.retire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/deq_dpath.sv @@
// Ring store, pointers and result registers of the double-ended queue.
// Depends on deq_pkg; sequenced by deq_ctrl through the command struct.
module deq_dpath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::deq_cmd_t                 cmd,
  input  logic [deq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [deq_pkg::WORD_W-1:0] in_value,
  output logic [deq_pkg::STAT_W-1:0]        out_status,
  output logic signed [deq_pkg::WORD_W-1:0] out_popped,
  output logic [deq_pkg::OCC_W-1:0]         out_occupancy
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Ring store; read data is registered
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic          pop_ok_r, pop_ok_nxt;

  logic          is_push, is_front, full, empty;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] front_dec, front_inc, back_pos, last_pos;
  logic [AW:0]   back_sum, last_sum;
  logic [CW+OCC_W-1:0] occ_ext;

  assign is_push  = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_BACK);
  assign is_front = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_POP_FRONT);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  // Ring positions, wrapped in both directions
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign back_sum  = (AW+1)'(front_r) + (AW+1)'(count_r);
  assign last_sum  = back_sum - (AW+1)'(1);
  assign back_pos  = (back_sum >= (AW+1)'(DEPTH)) ?
                     AW'(back_sum - (AW+1)'(DEPTH)) : AW'(back_sum);
  assign last_pos  = (last_sum >= (AW+1)'(DEPTH)) ?
                     AW'(last_sum - (AW+1)'(DEPTH)) : AW'(last_sum);

  // Decide the operation for the accepted beat
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = is_front ? front_dec : back_pos;
    rd_addr    = is_front ? front_r : last_pos;
    if (cmd.load) begin
      status_nxt = STAT_DONE;
      pop_ok_nxt = 1'b0;
      if (is_push) begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (is_front) front_nxt = front_dec;
        end
      end else begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          rd_en      = 1'b1;
          pop_ok_nxt = 1'b1;
          count_nxt  = count_r - CW'(1);
          if (is_front) front_nxt = front_inc;
        end
      end
    end
  end

  // Store access
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_value;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Pointer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      count_r  <= '0;
      status_r <= STAT_DONE;
      pop_ok_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      // drop the pop flag once the beat is gone
      pop_ok_r <= cmd.retire ? 1'b0 : pop_ok_nxt;
    end
  end

  assign occ_ext       = (CW+OCC_W)'(count_r);
  assign out_status    = status_r;
  assign out_popped    = pop_ok_r ? rd_data_r : '0;
  assign out_occupancy = occ_ext[OCC_W-1:0];

endmodule

@@ dv/tb_double_ended_queue.sv @@
// Self-checking testbench for double_ended_queue: directed edge cases, then random traffic.
// Predicts every result beat from its own model of the ring and compares field by field.
// Depends on deq_pkg and the double_ended_queue RTL only.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int Q_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  typedef enum {STALL_OFF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind = KIND_PUSH_FRONT;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_popped;
  logic [OCC_W-1:0]         out_occupancy;

  // Model of the ring store and its pointers
  logic signed [WORD_W-1:0] ring_words [Q_DEPTH];
  int                       head_pos = 0;
  int                       held_words = 0;

  // Results owed by the block, oldest first
  deq_result_t owed_results [$];

  int          errors = 0;
  int          ops_seen [4] = '{0, 0, 0, 0};
  int          beats_checked = 0;
  int          refused_pushes = 0;
  int          empty_pops = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  stall_mode_t stall_mode = STALL_OFF;
  int          stall_run = 0;

  double_ended_queue #(.DEPTH(Q_DEPTH)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_occupancy (out_occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2000000;
    $display("Timeout at %0t with %0d results outstanding", $time, owed_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one operation to the model ring and return the result it must produce
  function automatic deq_result_t apply_op(logic [KIND_W-1:0] kind,
                                           logic signed [WORD_W-1:0] word);
    deq_result_t r;
    int          pos;
    r.status = STAT_DONE;
    r.popped = '0;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
      if (held_words >= Q_DEPTH) begin
        r.status = STAT_FULL;
      end else if (kind == KIND_PUSH_FRONT) begin
        head_pos = (head_pos + Q_DEPTH - 1) % Q_DEPTH;
        ring_words[head_pos] = word;
        held_words++;
      end else begin
        pos = (head_pos + held_words) % Q_DEPTH;
        ring_words[pos] = word;
        held_words++;
      end
    end else begin
      if (held_words == 0) begin
        r.status = STAT_EMPTY;
      end else if (kind == KIND_POP_FRONT) begin
        r.popped = ring_words[head_pos];
        head_pos = (head_pos + 1) % Q_DEPTH;
        held_words--;
      end else begin
        pos = (head_pos + held_words - 1) % Q_DEPTH;
        r.popped = ring_words[pos];
        held_words--;
      end
    end
    r.occupancy = OCC_W'(held_words);
    return r;
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      owed_results.push_back(apply_op(in_kind, in_value));
      ops_seen[in_kind]++;
    end
  end

  // Check every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d popped %0d occupancy %0d",
                 $time, out_status, out_popped, out_occupancy);
      end else begin
        want = owed_results.pop_front();
        beats_checked++;
        if (want.status == STAT_FULL) refused_pushes++;
        if (want.status == STAT_EMPTY) empty_pops++;
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
        end
        if (out_popped !== want.popped) begin
          errors++;
          $display("%0t: popped mismatch: expected %0d, actual %0d",
                   $time, want.popped, out_popped);
        end
        if (out_occupancy !== want.occupancy) begin
          errors++;
          $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                   $time, want.occupancy, out_occupancy);
        end
      end
    end
  end

  // Receiver stall pattern: alternate runs of stall and ready
  always @(posedge clk) begin
    if (stall_mode == STALL_OFF) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, (stall_mode == STALL_HEAVY) ? 3 : 8);
    end else begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(0, (stall_mode == STALL_HEAVY) ? 20 : 3);
    end
  end

  // Send one input beat; hold it until taken, with bursty gaps ahead of it
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Random word, biased toward the extremes
  function automatic logic signed [WORD_W-1:0] pick_word();
    logic signed [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = 32'sh8000_0000;
      1:       w = 32'sh7fff_ffff;
      2:       w = '0;
      3:       w = -32'sd1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic test_empty_pops();
    send_item(KIND_POP_FRONT, 32'sh7fff_ffff);
    send_item(KIND_POP_BACK, 32'sh8000_0000);
  endtask

  // Fill from both ends with mostly extreme words, then push into the full queue
  task automatic test_fill_to_full();
    logic signed [WORD_W-1:0] word;
    for (int i = 0; i < Q_DEPTH; i++) begin
      case (i % 4)
        0: word = 32'sh8000_0000;
        1: word = 32'sh7fff_ffff;
        2: word = -32'sd1;
        default: word = $urandom;
      endcase
      send_item((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, word);
    end
    send_item(KIND_PUSH_FRONT, 32'sh5555_5555);
    send_item(KIND_PUSH_BACK, 32'shaaaa_aaaa);
  endtask

  task automatic test_pop_both_ends();
    send_item(KIND_POP_FRONT, '0);
    send_item(KIND_POP_BACK, -32'sd1);
    wait_idle();
  endtask

  task automatic test_random_mix(input int count, input stall_mode_t mode);
    stall_mode = mode;
    for (int i = 0; i < count; i++)
      send_item(KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_POP_BACK)), pick_word());
    wait_idle();
  endtask

  // Fill to full and drain to empty, with overruns and a little noise
  task automatic test_fill_drain(input int rounds);
    logic [KIND_W-1:0] kind;
    int                level;
    int                extra;
    stall_mode = STALL_LIGHT;
    wait_idle();
    level = held_words;
    for (int r = 0; r < rounds; r++) begin
      extra = $urandom_range(0, 2);
      while (level < Q_DEPTH || extra > 0) begin
        if (level == Q_DEPTH) extra--;
        if ($urandom_range(0, 9) == 0)
          kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        else
          kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        send_item(kind, pick_word());
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
          if (level < Q_DEPTH) level++;
        end else if (level > 0) begin
          level--;
        end
      end
      extra = $urandom_range(0, 2);
      while (level > 0 || extra > 0) begin
        if (level == 0) extra--;
        if ($urandom_range(0, 9) == 0)
          kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else
          kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        send_item(kind, pick_word());
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
          if (level < Q_DEPTH) level++;
        end else if (level > 0) begin
          level--;
        end
      end
    end
    wait_idle();
  endtask

  // Back-to-back FIFO-like traffic that walks the ring around many times
  task automatic test_streaming(input int count);
    logic [KIND_W-1:0] kind;
    int                level;
    sender_gaps = 1'b0;
    stall_mode = STALL_OFF;
    wait_idle();
    level = held_words;
    for (int i = 0; i < count; i++) begin
      if (level < 4)
        kind = KIND_PUSH_BACK;
      else if (level > 12)
        kind = KIND_POP_FRONT;
      else if ($urandom_range(0, 4) == 0)
        kind = KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_POP_BACK));
      else
        kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_POP_FRONT;
      send_item(kind, pick_word());
      if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
        if (level < Q_DEPTH) level++;
      end else if (level > 0) begin
        level--;
      end
    end
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_fill_to_full();
    test_pop_both_ends();
    test_random_mix(150, STALL_LIGHT);
    test_fill_drain(4);
    test_streaming(80);
    test_random_mix(60, STALL_HEAVY);

    // Let any stray result beat show up before closing
    stall_mode = STALL_OFF;
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d push-front, %0d push-back, %0d pop-front, %0d pop-back operations",
             ops_seen[KIND_PUSH_FRONT], ops_seen[KIND_PUSH_BACK],
             ops_seen[KIND_POP_FRONT], ops_seen[KIND_POP_BACK]);
    $display("Checked %0d results: %0d pushes refused when full, %0d pops on empty",
             beats_checked, refused_pushes, empty_pops);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
